[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the stillness window detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define SWD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("stillness window detector: invariant violated");
// Check that a condition in one cycle implies another in the next cycle.
`define SWD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stillness window detector: sequence violated");
`else
`define SWD_ASSERT_ALWAYS(lbl, cond)
`define SWD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/swd_pkg.sv]
// Shared constants and types of the stillness window detector.
package swd_pkg;

	// History geometry (DEPTH is a power of two)
	localparam int DEPTH      = 64;
	localparam int AW         = $clog2(DEPTH);
	localparam int CNT_W      = AW + 1;
	localparam int COORD_BITS = 16;
	localparam int IN_CW      = 16;

	// Field widths
	localparam int STAMP_W  = 32;
	localparam int FLAG_W   = 2;
	localparam int ENTRY_W  = STAMP_W + FLAG_W;
	localparam int CENTRE_W = 4 * COORD_BITS;
	localparam int FRAME_W  = 32;
	localparam int CAP_W    = 16;
	localparam int SPAN_W   = 16;
	localparam int MINW_W   = 6;
	localparam int THR_W    = 16;
	localparam int WIN_W    = 6;
	localparam int WIN_MAX  = 63;
	localparam int CMP_W    = (AW > MINW_W) ? AW : MINW_W;

	// Moment arithmetic widths
	localparam int N_W    = AW + 1;
	localparam int S1_W   = COORD_BITS + AW;
	localparam int S2_W   = 2 * COORD_BITS + AW;
	localparam int DIFF_W = N_W + S2_W;
	localparam int LIM_W  = 2 * N_W + 2 * THR_W;
	localparam int JW     = (DIFF_W > LIM_W) ? DIFF_W : LIM_W;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR  = 2'd2;
	localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd1000;
	localparam logic [MINW_W-1:0] MINW_RESET = 6'd10;
	localparam logic [THR_W-1:0]  THR_RESET  = 16'd16;

	// Both patterns found
	localparam logic [FLAG_W-1:0] FLAGS_ALL = 2'b11;

	// Stream widths
	localparam int S_TDATA_W = 96;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 1;

	// Control from the sequencer to the moment accumulator
	typedef struct packed {
		logic clr;
		logic add;
	} accum_ctl_t;

endpackage

[rtl/core/swd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
module swd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/swd_accum.sv]
// Per-coordinate sum and sum-of-squares accumulation plus the exact variance test.
module swd_accum (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swd_pkg::accum_ctl_t               ctl,
	input  logic [swd_pkg::CENTRE_W-1:0]      centre,
	input  logic [swd_pkg::N_W-1:0]           n,
	input  logic [swd_pkg::THR_W-1:0]         thr,
	output logic                              steady
);

	localparam int CB = swd_pkg::COORD_BITS;

	logic                               v_s1;
	logic [CB-1:0]                      x_s1   [4];
	logic [2*CB-1:0]                    sq_s1  [4];
	logic [swd_pkg::S1_W-1:0]           s1_q   [4];
	logic [swd_pkg::S2_W-1:0]           s2_q   [4];
	logic [swd_pkg::DIFF_W-1:0]         pa_s1  [4];
	logic [2*swd_pkg::S1_W-1:0]         pb_s1  [4];
	logic [2*swd_pkg::N_W-1:0]          nn_s1;
	logic [2*swd_pkg::THR_W-1:0]        tt_s1;
	logic [swd_pkg::DIFF_W-1:0]         diff_s2 [4];
	logic [swd_pkg::LIM_W-1:0]          lim_s2;
	logic [3:0]                         pass_c;

	// Hold the add strobe for the squaring stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctl.add & ~ctl.clr;
		end
	end

	// Square each coordinate, then accumulate
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			x_s1[c]  <= centre[c*CB +: CB];
			sq_s1[c] <= centre[c*CB +: CB] * centre[c*CB +: CB];
			if (ctl.clr) begin
				s1_q[c] <= '0;
				s2_q[c] <= '0;
			end else if (v_s1) begin
				s1_q[c] <= s1_q[c] + swd_pkg::S1_W'(x_s1[c]);
				s2_q[c] <= s2_q[c] + swd_pkg::S2_W'(sq_s1[c]);
			end
		end
	end

	// Form n*sum(x^2), (sum x)^2 and the squared factors of the limit
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			pa_s1[c] <= swd_pkg::DIFF_W'(n) * swd_pkg::DIFF_W'(s2_q[c]);
			pb_s1[c] <= s1_q[c] * s1_q[c];
		end
		nn_s1 <= swd_pkg::N_W'(n) * swd_pkg::N_W'(n);
		tt_s1 <= thr * thr;
	end

	// Subtract and build n^2*T^2
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			diff_s2[c] <= pa_s1[c] - swd_pkg::DIFF_W'(pb_s1[c]);
		end
		lim_s2 <= swd_pkg::LIM_W'(nn_s1) * swd_pkg::LIM_W'(tt_s1);
	end

	// Strict compare on all four coordinates
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			pass_c[c] = swd_pkg::JW'(diff_s2[c]) < swd_pkg::JW'(lim_s2);
		end
	end

	assign steady = &pass_c;

endmodule

[rtl/core/stillness_window_detector.sv]
// Top level of the stillness window detector: sequencer, history memories, result register.
//
//  channel  | direction | beat contents
//  s_axis   | in        | one frame: stamp, found flags, four centres
//  m_axis   | out       | one verdict per frame: capture, window, totals
//  cfg      | in        | register write: span, minimum window, threshold
//
// The age search and the moment pass each walk the history through the single read
// port of the memories, one entry a cycle, then a multiply and compare finishes the
// verdict. Reset clears control state and empties the history at once through the
// fill count; no clearing pass. A new frame is taken while the previous verdict
// still waits on m_axis.
`include "assert_macros.svh"
module stillness_window_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// time_ms, first_x, first_y, second_x, second_y
	input  logic [swd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// first_found, second_found
	input  logic [swd_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// window_frames, capture_total, frame_total, zero pad
	output logic [swd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// capture
	output logic [swd_pkg::M_TUSER_W-1:0]   m_axis_tuser,
	input  logic                            cfg_we,
	input  logic [swd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [swd_pkg::CFG_W-1:0]       cfg_data
);

	localparam int AW = swd_pkg::AW;
	localparam int CB = swd_pkg::COORD_BITS;
	localparam int IC = swd_pkg::IN_CW;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_SUM    = 3'd2;
	localparam logic [2:0] S_WAIT   = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;
	localparam logic [1:0] WAIT_LAST = 2'd2;

	logic [2:0]                     state_q;
	logic [swd_pkg::SPAN_W-1:0]     span_q;
	logic [swd_pkg::MINW_W-1:0]     minw_q;
	logic [swd_pkg::THR_W-1:0]      thr_q;
	logic [AW-1:0]                  newest_q;
	logic [swd_pkg::CNT_W-1:0]      fill_q;
	logic [swd_pkg::FRAME_W-1:0]    frames_q;
	logic [swd_pkg::CAP_W-1:0]      caps_q;
	logic [swd_pkg::STAMP_W-1:0]    t0_q;
	logic [swd_pkg::CNT_W-1:0]      iss_age_q;
	logic                           pend_q;
	logic [AW-1:0]                  pend_age_q;
	logic [AW-1:0]                  idx_q;
	logic                           all_found_q;
	logic                           cap_q;
	logic [1:0]                     wait_q;
	logic                           out_valid_q;
	logic                           out_cap_q;
	logic [swd_pkg::WIN_W-1:0]      out_win_q;
	logic [swd_pkg::CAP_W-1:0]      out_caps_q;
	logic [swd_pkg::FRAME_W-1:0]    out_frames_q;

	logic                           accept_c;
	logic [AW-1:0]                  wr_addr_c;
	logic [AW-1:0]                  rd_addr_c;
	logic [swd_pkg::ENTRY_W-1:0]    ent_wdata_c;
	logic [swd_pkg::CENTRE_W-1:0]   cen_wdata_c;
	logic [swd_pkg::ENTRY_W-1:0]    ent_rdata;
	logic [swd_pkg::CENTRE_W-1:0]   cen_rdata;
	logic [swd_pkg::STAMP_W-1:0]    rd_stamp_c;
	logic [swd_pkg::FLAG_W-1:0]     rd_flags_c;
	logic                           pend_empty_c;
	logic                           pend_old_c;
	logic                           pend_meets_min_c;
	logic                           zero_meets_min_c;
	logic                           steady;
	logic                           cap_c;
	logic [swd_pkg::WIN_W-1:0]      win_c;
	logic                           out_load_c;
	swd_pkg::accum_ctl_t            acc_ctl;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept_c      = s_axis_tvalid & s_axis_tready;

	// Pack the new entry and pick memory addresses
	assign wr_addr_c   = newest_q + AW'(1);
	assign rd_addr_c   = newest_q - iss_age_q[AW-1:0];
	assign ent_wdata_c = {s_axis_tuser[1], s_axis_tuser[0], s_axis_tdata[31:0]};
	assign cen_wdata_c = {CB'(s_axis_tdata[32+3*IC +: IC]), CB'(s_axis_tdata[32+2*IC +: IC]),
	                      CB'(s_axis_tdata[32+IC +: IC]), CB'(s_axis_tdata[32 +: IC])};

	swd_ram #(.WIDTH(swd_pkg::ENTRY_W), .DEPTH(swd_pkg::DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (accept_c),
		.waddr (wr_addr_c),
		.wdata (ent_wdata_c),
		.raddr (rd_addr_c),
		.rdata (ent_rdata)
	);

	swd_ram #(.WIDTH(swd_pkg::CENTRE_W), .DEPTH(swd_pkg::DEPTH)) u_centre_ram (
		.clk   (clk),
		.we    (accept_c),
		.waddr (wr_addr_c),
		.wdata (cen_wdata_c),
		.raddr (rd_addr_c),
		.rdata (cen_rdata)
	);

	// Classify the entry returned by the memory
	assign rd_stamp_c       = ent_rdata[swd_pkg::STAMP_W-1:0];
	assign rd_flags_c       = ent_rdata[swd_pkg::STAMP_W +: swd_pkg::FLAG_W];
	assign pend_empty_c     = (swd_pkg::CNT_W'(pend_age_q) >= fill_q) || (rd_stamp_c == '0);
	assign pend_old_c       = (t0_q - rd_stamp_c) > swd_pkg::STAMP_W'(span_q);
	assign pend_meets_min_c = swd_pkg::CMP_W'(pend_age_q) >= swd_pkg::CMP_W'(minw_q);
	assign zero_meets_min_c = (minw_q == '0);

	// Drive the accumulator: clear during the search, add on each returned entry
	assign acc_ctl.clr = (state_q == S_SEARCH);
	assign acc_ctl.add = (state_q == S_SUM) && pend_q;

	swd_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.centre (cen_rdata),
		.n      (swd_pkg::N_W'(idx_q) + swd_pkg::N_W'(1)),
		.thr    (thr_q),
		.steady (steady)
	);

	assign cap_c = all_found_q & steady;
	assign win_c = (swd_pkg::CMP_W'(idx_q) > swd_pkg::CMP_W'(swd_pkg::WIN_MAX)) ?
	               swd_pkg::WIN_W'(swd_pkg::WIN_MAX) : swd_pkg::WIN_W'(idx_q);
	assign out_load_c = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= swd_pkg::SPAN_RESET;
			minw_q <= swd_pkg::MINW_RESET;
			thr_q  <= swd_pkg::THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				swd_pkg::REG_SPAN: span_q <= cfg_data[swd_pkg::SPAN_W-1:0];
				swd_pkg::REG_MINW: minw_q <= cfg_data[swd_pkg::MINW_W-1:0];
				swd_pkg::REG_THR:  thr_q  <= cfg_data[swd_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: push, age search, moment pass, verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			newest_q    <= '0;
			fill_q      <= '0;
			frames_q    <= '0;
			caps_q      <= '0;
			iss_age_q   <= '0;
			pend_q      <= 1'b0;
			pend_age_q  <= '0;
			idx_q       <= '0;
			all_found_q <= 1'b0;
			cap_q       <= 1'b0;
			wait_q      <= '0;
			t0_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept_c) begin
						t0_q      <= s_axis_tdata[swd_pkg::STAMP_W-1:0];
						newest_q  <= wr_addr_c;
						frames_q  <= frames_q + swd_pkg::FRAME_W'(1);
						if (fill_q < swd_pkg::CNT_W'(swd_pkg::DEPTH)) begin
							fill_q <= fill_q + swd_pkg::CNT_W'(1);
						end
						iss_age_q <= swd_pkg::CNT_W'(1);
						pend_q    <= 1'b0;
						idx_q     <= '0;
						cap_q     <= 1'b0;
						state_q   <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					// issue the next age while the previous one returns
					pend_q     <= (iss_age_q < swd_pkg::CNT_W'(swd_pkg::DEPTH));
					pend_age_q <= iss_age_q[AW-1:0];
					iss_age_q  <= iss_age_q + swd_pkg::CNT_W'(1);
					if (pend_q) begin
						priority if (pend_empty_c) begin
							pend_q  <= 1'b0;
							state_q <= S_DONE;
						end else if (pend_old_c) begin
							pend_q    <= 1'b0;
							idx_q     <= pend_age_q;
							iss_age_q <= '0;
							state_q   <= pend_meets_min_c ? S_SUM : S_DONE;
						end else if (pend_age_q == AW'(swd_pkg::DEPTH - 1)) begin
							pend_q    <= 1'b0;
							iss_age_q <= '0;
							state_q   <= zero_meets_min_c ? S_SUM : S_DONE;
						end else begin
						end
					end
					all_found_q <= 1'b1;
				end
				S_SUM: begin
					pend_q     <= (iss_age_q <= swd_pkg::CNT_W'(idx_q));
					pend_age_q <= iss_age_q[AW-1:0];
					iss_age_q  <= iss_age_q + swd_pkg::CNT_W'(1);
					if (pend_q) begin
						if (rd_flags_c != swd_pkg::FLAGS_ALL) begin
							all_found_q <= 1'b0;
						end
						if (pend_age_q == idx_q) begin
							pend_q  <= 1'b0;
							wait_q  <= '0;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					wait_q <= wait_q + 2'd1;
					if (wait_q == WAIT_LAST) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cap_q <= cap_c;
					if (cap_c) begin
						caps_q <= caps_q + swd_pkg::CAP_W'(1);
						fill_q <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load_c) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register: load a verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_c) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_c) begin
			out_cap_q    <= cap_q;
			out_win_q    <= win_c;
			out_caps_q   <= caps_q;
			out_frames_q <= frames_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_cap_q;
	assign m_axis_tdata  = {2'b00, out_frames_q, out_caps_q, out_win_q};

	`SWD_ASSERT_ALWAYS(a_fill_bound, fill_q <= swd_pkg::CNT_W'(swd_pkg::DEPTH))
	`SWD_ASSERT_NEXT(a_accept_search, accept_c, state_q == S_SEARCH)
	`SWD_ASSERT_ALWAYS(a_sum_in_window, !(state_q == S_SUM && pend_q) || (pend_age_q <= idx_q))
	`SWD_ASSERT_NEXT(a_capture_empties, state_q == S_DECIDE && cap_c, fill_q == '0 && cap_q)

endmodule

[tb/swd_verdict_checker.sv]
// Verdict checker for the stillness window detector: predicts each verdict and compares it.
module swd_verdict_checker
	import swd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [S_TDATA_W-1:0]   s_axis_tdata,
	input  logic [S_TUSER_W-1:0]   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [M_TDATA_W-1:0]   m_axis_tdata,
	input  logic [M_TUSER_W-1:0]   m_axis_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     fail_count,
	output int                     verdicts_due,
	output int                     captures_seen
);

	typedef struct packed {
		logic                capture;
		logic [WIN_W-1:0]    window_frames;
		logic [CAP_W-1:0]    capture_total;
		logic [FRAME_W-1:0]  frame_total;
	} verdict_t;

	// Shadow registers and history
	logic [SPAN_W-1:0]      span_q;
	logic [MINW_W-1:0]      minw_q;
	logic [THR_W-1:0]       thr_q;
	logic [STAMP_W-1:0]     stamps [DEPTH];
	logic [FLAG_W-1:0]      found  [DEPTH];
	logic [COORD_BITS-1:0]  centres [DEPTH][4];
	logic [AW-1:0]          newest;
	int                     fill;
	logic [FRAME_W-1:0]     frames_q;
	logic [CAP_W-1:0]       caps_q;
	verdict_t               verdicts_pending [$];

	assign verdicts_due = verdicts_pending.size();

	// Push one frame into the history and work out its verdict
	function automatic verdict_t judge_frame(logic [S_TDATA_W-1:0] d, logic [S_TUSER_W-1:0] u);
		verdict_t v;
		logic [STAMP_W-1:0] t0;
		logic [AW-1:0] sl;
		logic [63:0] n, s1, s2, x, lim;
		int idx;
		bit ok, done, all_found, steady;
		newest = newest + 1'b1;
		t0 = d[31:0];
		stamps[newest] = t0;
		found[newest] = u;
		for (int c = 0; c < 4; c++)
			centres[newest][c] = d[32 + 16*c +: COORD_BITS];
		if (fill < DEPTH) fill++;
		frames_q = frames_q + 1;
		idx = 0;
		ok = 1;
		done = 0;
		for (int a = 1; a < DEPTH && !done; a++) begin
			sl = newest - AW'(a);
			if (a >= fill || stamps[sl] == '0) begin
				ok = 0;
				done = 1;
			end else if ((t0 - stamps[sl]) > {16'd0, span_q}) begin
				idx = a;
				done = 1;
			end
		end
		v.capture = 1'b0;
		if (ok && idx >= minw_q) begin
			all_found = 1;
			for (int a = 0; a <= idx; a++)
				if (found[newest - AW'(a)] != FLAGS_ALL) all_found = 0;
			if (all_found) begin
				n = idx + 1;
				lim = n * n * {48'd0, thr_q} * {48'd0, thr_q};
				steady = 1;
				for (int c = 0; c < 4; c++) begin
					s1 = 0;
					s2 = 0;
					for (int a = 0; a <= idx; a++) begin
						x = centres[newest - AW'(a)][c];
						s1 += x;
						s2 += x * x;
					end
					if (!((n * s2 - s1 * s1) < lim)) steady = 0;
				end
				if (steady) begin
					v.capture = 1'b1;
					caps_q = caps_q + 1'b1;
					for (int a = 0; a < DEPTH; a++) stamps[a] = '0;
					fill = 0;
				end
			end
		end
		v.window_frames = (idx > WIN_MAX) ? WIN_W'(WIN_MAX) : WIN_W'(idx);
		v.capture_total = caps_q;
		v.frame_total = frames_q;
		return v;
	endfunction

	// Track writes, compare verdict beats, then predict new frames
	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			span_q = SPAN_RESET;
			minw_q = MINW_RESET;
			thr_q = THR_RESET;
			for (int a = 0; a < DEPTH; a++) begin
				stamps[a] = '0;
				found[a] = '0;
			end
			newest = '0;
			fill = 0;
			frames_q = '0;
			caps_q = '0;
			fail_count <= 0;
			captures_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SPAN: span_q = cfg_data[SPAN_W-1:0];
					REG_MINW: minw_q = cfg_data[MINW_W-1:0];
					REG_THR: thr_q = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.capture = m_axis_tuser[0];
				got.window_frames = m_axis_tdata[5:0];
				got.capture_total = m_axis_tdata[21:6];
				got.frame_total = m_axis_tdata[53:22];
				if (got.capture) captures_seen <= captures_seen + 1;
				if (verdicts_pending.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected verdict beat: cap=%0d win=%0d caps=%0d frames=%0d",
							got.capture, got.window_frames, got.capture_total,
							got.frame_total);
					fail_count <= fail_count + 1;
				end else begin
					want = verdicts_pending.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("verdict mismatch: exp cap=%0d win=%0d caps=%0d frames=%0d, got cap=%0d win=%0d caps=%0d frames=%0d",
								want.capture, want.window_frames, want.capture_total,
								want.frame_total, got.capture, got.window_frames,
								got.capture_total, got.frame_total);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				verdicts_pending.push_back(judge_frame(s_axis_tdata, s_axis_tuser));
		end
	end

endmodule

[tb/stillness_window_detector_tb.sv]
// Testbench top of the stillness window detector: clock, reset, stimulus and verdict.
module stillness_window_detector_tb;
	import swd_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [M_TUSER_W-1:0]  m_axis_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	int                    fail_count, verdicts_due, captures_seen;
	int                    cycles = 0, frames_sent = 0, burst_left = 0;
	int                    ready_hold = 0, ready_mode = 0;
	logic [31:0]           clock_ms = 32'd1;
	logic [15:0]           span_set = SPAN_RESET, thr_set = THR_RESET;
	logic [5:0]            minw_set = MINW_RESET;

	always #5 clk = ~clk;

	stillness_window_detector uut (.*);

	swd_verdict_checker checker_i (.*);

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver back-pressure: ready runs, stall runs and cycle-by-cycle noise
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_hold = (ready_mode == 0) ? $urandom_range(1, 60) : $urandom_range(1, 30);
		end else ready_hold--;
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'b0;
			default: m_axis_tready <= $urandom_range(0, 1);
		endcase
	end

	// Send one frame beat; pause between bursts
	task automatic send_frame(logic [31:0] t, logic [1:0] flg, logic [15:0] fx, logic [15:0] fy,
		logic [15:0] sx, logic [15:0] sy);
		s_axis_tdata <= {sy, sx, fy, fx, t};
		s_axis_tuser <= flg;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		frames_sent++;
		if (burst_left > 0) burst_left--;
		else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end
	endtask

	// Drain verdicts, then write the registers while the block is idle
	task automatic write_regs(logic [15:0] span, logic [15:0] minw_raw, logic [15:0] thr);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts_due != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SPAN;
		cfg_data <= span;
		@(posedge clk);
		cfg_idx <= REG_MINW;
		cfg_data <= minw_raw;
		@(posedge clk);
		cfg_idx <= REG_THR;
		cfg_data <= thr;
		@(posedge clk);
		cfg_idx <= 2'd3;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		span_set = span;
		minw_set = minw_raw[5:0];
		thr_set = thr;
	endtask

	// Steady frames with occasional noise frames, spaced so the window closes near the minimum index
	task automatic run_phase(int count);
		logic [15:0] base [4];
		logic [15:0] pos [4];
		int step, amp, jit;
		for (int k = 0; k < count; k++) begin
			if (k % 30 == 0)
				for (int c = 0; c < 4; c++) base[c] = 16'($urandom);
			step = span_set / (minw_set + $urandom_range(0, 3) + 1) + 1;
			amp = (thr_set * $urandom_range(1, 30)) / 10 + 1;
			if ($urandom_range(0, 99) < 10) begin
				// noise frame
				if ($urandom_range(0, 2) == 0) clock_ms = $urandom;
				send_frame($urandom_range(0, 3) == 0 ? clock_ms - $urandom_range(0, 5000)
					: clock_ms, 2'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			end else begin
				clock_ms = clock_ms + step + $urandom_range(0, step / 8);
				if ($urandom_range(0, 199) == 0) clock_ms = $urandom;
				for (int c = 0; c < 4; c++) begin
					jit = $urandom_range(0, 2 * amp) - amp;
					pos[c] = base[c] + 16'(jit);
				end
				send_frame(clock_ms, ($urandom_range(0, 99) < 96) ? FLAGS_ALL : 2'($urandom),
					pos[0], pos[1], pos[2], pos[3]);
			end
		end
	endtask

	initial begin
		logic [15:0] sp, mw, th;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero stamp, flag mixes, coordinate extremes, time running backwards
		send_frame(32'd0, 2'b11, 16'd0, 16'd0, 16'd0, 16'd0);
		send_frame(32'd5, 2'b01, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_frame(32'd9, 2'b10, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_frame(32'hFFFF_FFFF, 2'b00, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_frame(32'd3, 2'b11, 16'd100, 16'd200, 16'd300, 16'd400);
		// Steady window under the reset settings should capture
		for (int k = 1; k <= 13; k++)
			send_frame(32'd2000 + 100 * k, FLAGS_ALL, 16'd1000 + k % 3, 16'd2000 - k % 4,
				16'd3000 + k % 5, 16'd4000);

		// Extreme settings first, then random ones
		write_regs(16'd0, 16'd0, 16'hFFFF);
		run_phase(80);
		write_regs(16'hFFFF, 16'hFFFF, 16'd0);
		run_phase(60);
		write_regs(16'd1000, 16'd1, 16'd200);
		run_phase(100);
		write_regs(16'd3000, 16'd63, 16'd400);
		run_phase(120);
		for (int p = 0; p < 8; p++) begin
			sp = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(50, 3000));
			mw = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
			th = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 400));
			write_regs(sp, mw, th);
			run_phase(95);
		end

		// Drain and settle
		s_axis_tvalid <= 1'b0;
		while (verdicts_due != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d frames over 12 register settings, %0d captures observed",
			frames_sent, captures_seen);
		if (fail_count == 0 && verdicts_due == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/swd_pkg.sv
rtl/core/swd_ram.sv
rtl/core/swd_accum.sv
rtl/core/stillness_window_detector.sv
tb/swd_verdict_checker.sv
tb/stillness_window_detector_tb.sv
